// ----- rtl/lew_pkg.sv -----
// ----------------------------------------------------------------------------
// lew_pkg: shared types and constants of the lattice exclusion walk core
// Payload structs, operation and status codes, register indexes, the
// sequencer states and the modulo-three reduction used by the move picker.
// ----------------------------------------------------------------------------
package lew_pkg;

   localparam int SIDE_DEF   = 64;
   localparam int ID_W       = 12;
   localparam int POS_W      = 6;
   localparam int SZ_W       = 7;
   localparam int ORG_W      = 12;
   localparam int FULL_W     = 13;
   localparam int RND_W      = 16;
   localparam int OP_W       = 2;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE   = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OOB   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SUB_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_HEIGHT = 3'd5;

   localparam logic [SZ_W-1:0]   SUB_SIZE_RST  = 7'd64;
   localparam logic [ORG_W-1:0]  ORIGIN_RST    = 12'd0;
   localparam logic [FULL_W-1:0] FULL_SIZE_RST = 13'd64;

   typedef enum logic [1:0] {
      DIR_DOWN  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_LEFT  = 2'd3
   } lew_dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_PROBE,
      ST_DECIDE,
      ST_WR_TARGET,
      ST_WR_CENTER
   } lew_state_type;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [ID_W-1:0]  walker_index;
      logic [RND_W-1:0] random_value;
   } lew_req_type;

   typedef struct packed {
      logic [POS_W-1:0]  result_x;
      logic [POS_W-1:0]  result_y;
      logic [ID_W-1:0]   result_walker;
      logic              did_move;
      logic [STAT_W-1:0] status;
   } lew_rsp_type;

   typedef struct packed {
      logic            used;
      logic [ID_W-1:0] id;
   } lew_entry_type;

   typedef struct packed {
      logic free_up;
      logic free_down;
      logic free_right;
      logic free_left;
   } lew_nbr_type;

   typedef struct packed {
      logic edge_l;
      logic edge_r;
      logic edge_b;
      logic edge_t;
      logic out_l;
      logic out_r;
      logic out_b;
      logic out_t;
   } lew_border_type;

   typedef struct packed {
      logic        moved;
      lew_dir_type dir;
   } lew_pick_type;

   // 4 = 1 mod 3, so base-4 digit sums keep the residue
   function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = '0;
      for (int i = 0; i < RND_W / 2; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
   endfunction

endpackage

// ----- rtl/lattice_exclusion_walk_step_core.sv -----
// ----------------------------------------------------------------------------
// lattice_exclusion_walk_step_core: one sub-grid of an exclusion random walk
// Create, move and remove walkers in a cell memory, with a sequencer that
// probes the addressed cell and its neighbors through one read port.
//
//   Channel  Ports                               Beat
//   req      start, busy, req_data               start high while busy low
//   rsp      rsp_strobe, rsp_data                one cycle, strobe high
//   csr      csr_write, csr_index, csr_data      csr_write high
//
// After accept, busy holds through the request check (create, out of range,
// op 3), the center probe (remove, move from an empty cell), the neighbor
// probes (move, no relocation) and the target and center writes (move that
// relocates); the result shows in the first cycle with busy low. The probes
// go through the single read port of the cell memory, one probe per cycle.
// Reset clearing of every cell holds busy. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module lattice_exclusion_walk_step_core #(
   parameter int SIDE = lew_pkg::SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lew_pkg::lew_req_type              req_data,
   output logic                              rsp_strobe,
   output lew_pkg::lew_rsp_type              rsp_data,
   input  logic                              csr_write,
   input  logic [lew_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lew_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lew_pkg::*;

   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = ($clog2(SIDE + 1) > SZ_W) ? $clog2(SIDE + 1) : SZ_W;

   localparam logic [2:0] PRB_CENTER = 3'd0;
   localparam logic [2:0] PRB_UP     = 3'd1;
   localparam logic [2:0] PRB_DOWN   = 3'd2;
   localparam logic [2:0] PRB_RIGHT  = 3'd3;
   localparam logic [2:0] PRB_LEFT   = 3'd4;
   localparam logic [2:0] PRB_END    = 3'd5;

   function automatic logic [AW-1:0] addr_of(input logic [POS_W-1:0] cx,
                                             input logic [POS_W-1:0] cy);
      return AW'(cx) * AW'(SIDE) + AW'(cy);
   endfunction

   lew_state_type  state_ff, state_in;
   lew_req_type    req_ff, req_in;
   logic [2:0]     k_ff, k_in;
   logic [ID_W-1:0] walker_ff, walker_in;
   lew_nbr_type    nbr_ff, nbr_in;
   lew_border_type border_ff, border_in;
   lew_pick_type   pick_ff, pick_in;
   lew_rsp_type    rsp_ff, rsp_in;
   logic           rsp_strobe_ff, rsp_strobe_in;

   logic [SZ_W-1:0]   sub_width_ff, sub_width_in;
   logic [SZ_W-1:0]   sub_height_ff, sub_height_in;
   logic [ORG_W-1:0]  origin_x_ff, origin_x_in;
   logic [ORG_W-1:0]  origin_y_ff, origin_y_in;
   logic [FULL_W-1:0] full_width_ff, full_width_in;
   logic [FULL_W-1:0] full_height_ff, full_height_in;

   logic              clearing;
   logic              accept;
   logic [EW-1:0]     eff_w, eff_h, xw, yw;
   logic              in_box, op_valid;
   logic              up_ok, down_ok, right_ok, left_ok;
   logic [FULL_W-1:0] gx, gy;
   lew_border_type    border_now;
   lew_pick_type      pick_now;
   logic [POS_W-1:0]  prb_x, prb_y, tgt_x, tgt_y;
   lew_rsp_type       rsp_base;

   logic              mem_rd_en, mem_wr_en;
   logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
   lew_entry_type     mem_rd_data, mem_wr_data;

   lew_cell_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_data  (mem_rd_data),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data)
   );

   lew_move_pick u_pick (
      .nbr          (nbr_ff),
      .border       (border_ff),
      .random_value (req_ff.random_value),
      .pick         (pick_now)
   );

   assign busy   = clearing || (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // geometry of the addressed cell
   always_comb begin
      eff_w    = (EW'(sub_width_ff) > EW'(SIDE)) ? EW'(SIDE) : EW'(sub_width_ff);
      eff_h    = (EW'(sub_height_ff) > EW'(SIDE)) ? EW'(SIDE) : EW'(sub_height_ff);
      xw       = EW'(req_ff.pos_x);
      yw       = EW'(req_ff.pos_y);
      in_box   = (xw < eff_w) && (yw < eff_h);
      op_valid = (req_ff.operation == OP_CREATE) || (req_ff.operation == OP_MOVE) ||
                 (req_ff.operation == OP_REMOVE);
      up_ok    = (yw + EW'(1)) < eff_h;
      down_ok  = (yw != '0);
      right_ok = (xw + EW'(1)) < eff_w;
      left_ok  = (xw != '0);
      gx       = FULL_W'(req_ff.pos_x) + FULL_W'(origin_x_ff);
      gy       = FULL_W'(req_ff.pos_y) + FULL_W'(origin_y_ff);
      border_now.edge_l = (xw == '0);
      border_now.edge_r = !border_now.edge_l && (xw == eff_w - EW'(1));
      border_now.edge_b = (yw == '0);
      border_now.edge_t = !border_now.edge_b && (yw == eff_h - EW'(1));
      border_now.out_l  = (gx == '0);
      border_now.out_b  = (gy == '0);
      border_now.out_r  = !border_now.out_l && (full_width_ff != '0) &&
                          (gx == full_width_ff - FULL_W'(1));
      border_now.out_t  = !border_now.out_b && (full_height_ff != '0) &&
                          (gy == full_height_ff - FULL_W'(1));
   end

   always_comb begin
      prb_x = req_ff.pos_x;
      prb_y = req_ff.pos_y;
      unique case (k_ff)
         PRB_UP:    prb_y = req_ff.pos_y + POS_W'(1);
         PRB_DOWN:  prb_y = req_ff.pos_y - POS_W'(1);
         PRB_RIGHT: prb_x = req_ff.pos_x + POS_W'(1);
         PRB_LEFT:  prb_x = req_ff.pos_x - POS_W'(1);
         default: begin
         end
      endcase
      tgt_x = req_ff.pos_x;
      tgt_y = req_ff.pos_y;
      unique case (pick_ff.dir)
         DIR_UP:    tgt_y = req_ff.pos_y + POS_W'(1);
         DIR_DOWN:  tgt_y = req_ff.pos_y - POS_W'(1);
         DIR_RIGHT: tgt_x = req_ff.pos_x + POS_W'(1);
         DIR_LEFT:  tgt_x = req_ff.pos_x - POS_W'(1);
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!op_valid || !in_box || (req_ff.operation == OP_CREATE)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (k_ff == PRB_UP) begin
               if (!mem_rd_data.used || (req_ff.operation == OP_REMOVE)) begin
                  state_in = ST_IDLE;
               end
            end else if (k_ff == PRB_END) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = pick_now.moved ? ST_WR_TARGET : ST_IDLE;
         end
         ST_WR_TARGET: state_in = ST_WR_CENTER;
         ST_WR_CENTER: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in        = req_ff;
      k_in          = k_ff;
      walker_in     = walker_ff;
      nbr_in        = nbr_ff;
      border_in     = border_ff;
      pick_in       = pick_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = addr_of(prb_x, prb_y);
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_of(req_ff.pos_x, req_ff.pos_y);
      mem_wr_data   = '0;

      rsp_base.result_x      = req_ff.pos_x;
      rsp_base.result_y      = req_ff.pos_y;
      rsp_base.result_walker = '0;
      rsp_base.did_move      = 1'b0;
      rsp_base.status        = STAT_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
            end
         end
         ST_LOOK: begin
            border_in = border_now;
            k_in      = PRB_CENTER;
            priority if (!op_valid) begin
               rsp_in        = rsp_base;
               rsp_strobe_in = 1'b1;
            end else if (!in_box) begin
               rsp_in        = rsp_base;
               rsp_in.status = STAT_OOB;
               rsp_strobe_in = 1'b1;
            end else if (req_ff.operation == OP_CREATE) begin
               mem_wr_en              = 1'b1;
               mem_wr_data.used       = 1'b1;
               mem_wr_data.id         = req_ff.walker_index;
               rsp_in                 = rsp_base;
               rsp_in.result_walker   = req_ff.walker_index;
               rsp_strobe_in          = 1'b1;
            end else begin
            end
         end
         ST_PROBE: begin
            mem_rd_en = (k_ff != PRB_END);
            k_in      = k_ff + 3'd1;
            unique case (k_ff)
               PRB_UP: begin
                  walker_in = mem_rd_data.id;
                  if (!mem_rd_data.used) begin
                     rsp_in        = rsp_base;
                     rsp_in.status = STAT_EMPTY;
                     rsp_strobe_in = 1'b1;
                  end else if (req_ff.operation == OP_REMOVE) begin
                     mem_wr_en            = 1'b1;
                     rsp_in               = rsp_base;
                     rsp_in.result_walker = mem_rd_data.id;
                     rsp_strobe_in        = 1'b1;
                  end
               end
               PRB_DOWN:  nbr_in.free_up    = up_ok && !mem_rd_data.used;
               PRB_RIGHT: nbr_in.free_down  = down_ok && !mem_rd_data.used;
               PRB_LEFT:  nbr_in.free_right = right_ok && !mem_rd_data.used;
               PRB_END:   nbr_in.free_left  = left_ok && !mem_rd_data.used;
               default: begin
               end
            endcase
         end
         ST_DECIDE: begin
            pick_in = pick_now;
            if (!pick_now.moved) begin
               rsp_in               = rsp_base;
               rsp_in.result_walker = walker_ff;
               rsp_strobe_in        = 1'b1;
            end
         end
         ST_WR_TARGET: begin
            mem_wr_en        = 1'b1;
            mem_wr_addr      = addr_of(tgt_x, tgt_y);
            mem_wr_data.used = 1'b1;
            mem_wr_data.id   = walker_ff;
         end
         ST_WR_CENTER: begin
            mem_wr_en              = 1'b1;
            rsp_in.result_x        = tgt_x;
            rsp_in.result_y        = tgt_y;
            rsp_in.result_walker   = walker_ff;
            rsp_in.did_move        = 1'b1;
            rsp_in.status          = STAT_OK;
            rsp_strobe_in          = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // configuration registers
   always_comb begin
      sub_width_in   = sub_width_ff;
      sub_height_in  = sub_height_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      full_width_in  = full_width_ff;
      full_height_in = full_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SUB_WIDTH:   sub_width_in   = csr_data[SZ_W-1:0];
            CSR_SUB_HEIGHT:  sub_height_in  = csr_data[SZ_W-1:0];
            CSR_ORIGIN_X:    origin_x_in    = csr_data[ORG_W-1:0];
            CSR_ORIGIN_Y:    origin_y_in    = csr_data[ORG_W-1:0];
            CSR_FULL_WIDTH:  full_width_in  = csr_data[FULL_W-1:0];
            CSR_FULL_HEIGHT: full_height_in = csr_data[FULL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_strobe_ff  <= 1'b0;
         sub_width_ff   <= SUB_SIZE_RST;
         sub_height_ff  <= SUB_SIZE_RST;
         origin_x_ff    <= ORIGIN_RST;
         origin_y_ff    <= ORIGIN_RST;
         full_width_ff  <= FULL_SIZE_RST;
         full_height_ff <= FULL_SIZE_RST;
      end else begin
         state_ff       <= state_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         sub_width_ff   <= sub_width_in;
         sub_height_ff  <= sub_height_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         full_width_ff  <= full_width_in;
         full_height_ff <= full_height_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      k_ff      <= k_in;
      walker_ff <= walker_in;
      nbr_ff    <= nbr_in;
      border_ff <= border_in;
      pick_ff   <= pick_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/lew_cell_mem.sv -----
// ----------------------------------------------------------------------------
// lew_cell_mem: cell occupancy memory
// One write port and one registered read port. After reset a sweep writes
// every entry empty, one per cycle, and clearing stays high meanwhile.
// ----------------------------------------------------------------------------
module lew_cell_mem #(
   parameter int DEPTH = lew_pkg::SIDE_DEF * lew_pkg::SIDE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      clearing,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output lew_pkg::lew_entry_type    rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  lew_pkg::lew_entry_type    wr_data
);
   import lew_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   lew_entry_type cells_mem [DEPTH];
   lew_entry_type rd_data_ff;
   logic          clear_ff;
   logic          clear_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         cells_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule

// ----- rtl/lew_move_pick.sv -----
// ----------------------------------------------------------------------------
// lew_move_pick: candidate move list and draw
// Orders the candidate moves from the neighbor and border flags, reduces
// the random draw modulo the list length and reports the chosen direction.
// ----------------------------------------------------------------------------
module lew_move_pick (
   input  lew_pkg::lew_nbr_type            nbr,
   input  lew_pkg::lew_border_type         border,
   input  logic [lew_pkg::RND_W-1:0]       random_value,
   output lew_pkg::lew_pick_type           pick
);
   import lew_pkg::*;

   logic [3:0]  cond;
   lew_dir_type slot_dir [4];
   lew_dir_type lst [4];
   logic [2:0]  cnt;
   logic [1:0]  sel;
   lew_dir_type dir;
   logic        dir_free;

   always_comb begin
      cond = '0;
      for (int i = 0; i < 4; i++) begin
         slot_dir[i] = DIR_DOWN;
      end
      if (border.edge_l || border.edge_r || border.edge_b || border.edge_t) begin
         if (border.edge_b) begin
            cond[0] = nbr.free_up;   slot_dir[0] = DIR_UP;
            cond[1] = !border.out_b; slot_dir[1] = DIR_DOWN;
         end else if (border.edge_t) begin
            cond[0] = nbr.free_down; slot_dir[0] = DIR_DOWN;
            cond[1] = !border.out_t; slot_dir[1] = DIR_UP;
         end else begin
            cond[0] = nbr.free_up;   slot_dir[0] = DIR_UP;
            cond[1] = nbr.free_down; slot_dir[1] = DIR_DOWN;
         end
         if (border.edge_r) begin
            cond[2] = nbr.free_left;  slot_dir[2] = DIR_LEFT;
            cond[3] = !border.out_r;  slot_dir[3] = DIR_RIGHT;
         end else if (border.edge_l) begin
            cond[2] = nbr.free_right; slot_dir[2] = DIR_RIGHT;
            cond[3] = !border.out_l;  slot_dir[3] = DIR_LEFT;
         end else begin
            cond[2] = nbr.free_left;  slot_dir[2] = DIR_LEFT;
            cond[3] = nbr.free_right; slot_dir[3] = DIR_RIGHT;
         end
      end else begin
         cond[0] = nbr.free_right; slot_dir[0] = DIR_RIGHT;
         cond[1] = nbr.free_left;  slot_dir[1] = DIR_LEFT;
         cond[2] = nbr.free_up;    slot_dir[2] = DIR_UP;
         cond[3] = nbr.free_down;  slot_dir[3] = DIR_DOWN;
      end
   end

   // pack the listed moves to the front
   always_comb begin
      cnt = '0;
      for (int i = 0; i < 4; i++) begin
         lst[i] = DIR_DOWN;
      end
      for (int i = 0; i < 4; i++) begin
         if (cond[i]) begin
            lst[cnt[1:0]] = slot_dir[i];
            cnt = cnt + 3'd1;
         end
      end
   end

   always_comb begin
      unique case (cnt)
         3'd2:    sel = {1'b0, random_value[0]};
         3'd3:    sel = mod3_16(random_value);
         3'd4:    sel = random_value[1:0];
         default: sel = 2'd0;
      endcase
      dir = lst[sel];
      unique case (dir)
         DIR_UP:    dir_free = nbr.free_up;
         DIR_DOWN:  dir_free = nbr.free_down;
         DIR_RIGHT: dir_free = nbr.free_right;
         DIR_LEFT:  dir_free = nbr.free_left;
         default:   dir_free = 1'b0;
      endcase
      pick.dir   = dir;
      pick.moved = (cnt != 3'd0) && dir_free;
   end

endmodule

// ----- rtl/lew_checker.sv -----
// ----------------------------------------------------------------------------
// lew_checker: port-level checks of the walk core
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module lew_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input lew_pkg::lew_rsp_type  rsp_data
);
   import lew_pkg::*;

   // an accepted beat always raises busy in the cycle after it
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while core busy");

   a_move_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.did_move |-> rsp_data.status == STAT_OK)
      else $error("relocation reported with error status");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == STAT_OOB || rsp_data.status == STAT_EMPTY)
      |-> !rsp_data.did_move && rsp_data.result_walker == '0)
      else $error("failed beat carries a walker or a move");

endmodule

bind lattice_exclusion_walk_step_core lew_checker u_lew_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
